>>> rtl/tga_rle_image_decoder_assert.svh
// Assertion macros used by the TGA run-length decoder top level.
`ifndef TGA_RLE_IMAGE_DECODER_ASSERT_SVH
`define TGA_RLE_IMAGE_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, disabled during reset.
`define TGA_RLE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled during reset.
`define TGA_RLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TGA_RLE_ASSERT_IMPLY(label, ante, cons, msg)
`define TGA_RLE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/tga_rle_pkg.sv
// Shared types and constants of the TGA run-length decoder.
package tga_rle_pkg;

    // Header layout.
    localparam logic [4:0] HB_ID_LEN   = 5'd0;
    localparam logic [4:0] HB_MAP_TYPE = 5'd1;
    localparam logic [4:0] HB_IMG_TYPE = 5'd2;
    localparam logic [4:0] HB_WIDTH_LO = 5'd12;
    localparam logic [4:0] HB_WIDTH_HI = 5'd13;
    localparam logic [4:0] HB_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HB_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HB_BPP      = 5'd16;
    localparam logic [4:0] HB_LAST     = 5'd17;

    // Image types, pixel sizes, opaque alpha and minimum width.
    localparam logic [7:0] TYPE_RAW      = 8'd2;
    localparam logic [7:0] TYPE_RLE      = 8'd10;
    localparam logic [7:0] BPP_24        = 8'd24;
    localparam logic [7:0] BPP_32        = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;
    localparam logic [15:0] MIN_WIDTH    = 16'd4;

    // Result status codes.
    localparam logic [1:0] STAT_SEG        = 2'd0;
    localparam logic [1:0] STAT_BAD_TYPE   = 2'd1;
    localparam logic [1:0] STAT_BAD_FORMAT = 2'd2;
    localparam logic [1:0] STAT_NARROW     = 2'd3;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_SKIP,
        ST_PKTHDR,
        ST_PIXEL,
        ST_EMIT,
        ST_REPORT,
        ST_DONE,
        ST_ERROR
    } tga_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic hdr_byte;
        logic skip_byte;
        logic enter_data;
        logic pkt_hdr;
        logic pix_byte;
        logic start_span;
        logic emit_seg;
        logic emit_err;
    } tga_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       hdr_last;
        logic [1:0] err_code;
        logic       id_nonzero;
        logic       skip_last;
        logic       height_zero;
        logic       is_rle;
        logic       pix_complete;
        logic       pkt_empty;
        logic       slot_free;
        logic       emit_last;
        logic       seg_done;
    } tga_sts_t;

endpackage

>>> rtl/tga_rle_ctrl.sv
// Controller state machine of the TGA run-length decoder.
module tga_rle_ctrl
    import tga_rle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     start_of_file,
    output logic     in_stall,
    input  tga_sts_t sts,
    output tga_cmd_t cmd
);

    tga_state_t state_reg;
    tga_state_t state_next;
    tga_state_t cur_state;
    tga_state_t data_state;
    logic       accept;

    assign in_stall = (state_reg == ST_EMIT) || (state_reg == ST_REPORT);
    assign accept   = in_valid && !in_stall;

    // An accepted start-of-file word restarts header parsing from any phase that takes input.
    assign cur_state = (accept && start_of_file) ? ST_HEADER : state_reg;

    assign data_state = sts.height_zero ? ST_DONE : (sts.is_rle ? ST_PKTHDR : ST_PIXEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (cur_state)
            ST_HEADER:
            begin
                if (accept)
                begin
                    priority if (!sts.hdr_last)
                        state_next = ST_HEADER;
                    else if (sts.err_code != STAT_SEG)
                        state_next = ST_REPORT;
                    else if (sts.id_nonzero)
                        state_next = ST_SKIP;
                    else
                        state_next = data_state;
                end
            end
            ST_SKIP:
            begin
                if (accept && sts.skip_last)
                    state_next = data_state;
            end
            ST_PKTHDR:
            begin
                if (accept)
                    state_next = ST_PIXEL;
            end
            ST_PIXEL:
            begin
                if (accept && sts.pix_complete)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.slot_free && sts.emit_last)
                begin
                    priority if (sts.seg_done)
                        state_next = ST_DONE;
                    else if (sts.is_rle && sts.pkt_empty)
                        state_next = ST_PKTHDR;
                    else
                        state_next = ST_PIXEL;
                end
            end
            ST_REPORT:
            begin
                if (sts.slot_free)
                    state_next = ST_ERROR;
            end
            ST_DONE:  state_next = ST_DONE;
            ST_ERROR: state_next = ST_ERROR;
            default:  state_next = ST_HEADER;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (cur_state)
            ST_HEADER:
            begin
                cmd.hdr_byte   = accept;
                cmd.enter_data = accept && sts.hdr_last && (sts.err_code == STAT_SEG)
                                 && !sts.id_nonzero;
            end
            ST_SKIP:
            begin
                cmd.skip_byte  = accept;
                cmd.enter_data = accept && sts.skip_last;
            end
            ST_PKTHDR:
            begin
                cmd.pkt_hdr = accept;
            end
            ST_PIXEL:
            begin
                cmd.pix_byte   = accept;
                cmd.start_span = accept && sts.pix_complete;
            end
            ST_EMIT:
            begin
                cmd.emit_seg = sts.slot_free;
            end
            ST_REPORT:
            begin
                cmd.emit_err = sts.slot_free;
            end
            ST_DONE:  cmd = '0;
            ST_ERROR: cmd = '0;
            default:  cmd = '0;
        endcase
    end

endmodule

>>> rtl/tga_rle_dp.sv
// Datapath of the TGA run-length decoder: header, pixel and span registers.
module tga_rle_dp
    import tga_rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    input  tga_cmd_t    cmd,
    output tga_sts_t    sts,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [1:0]  status,
    output logic [15:0] dest_row,
    output logic [15:0] start_column,
    output logic [7:0]  pixel_count,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic        last_of_run,
    output logic        image_done,
    output logic [15:0] image_width,
    output logic [15:0] image_height
);

    logic [4:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]  id_skip_reg, id_skip_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  map_reg, map_next;
    logic [7:0]  bpp_reg, bpp_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  pkt_left_reg, pkt_left_next;
    logic        pkt_run_reg, pkt_run_next;
    logic [1:0]  bip_reg, bip_next;
    logic [31:0] color_reg, color_next;
    logic [15:0] row_reg, row_next;
    logic [15:0] col_reg, col_next;
    logic [7:0]  count_reg, count_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  o_status_reg;
    logic [15:0] o_row_reg;
    logic [15:0] o_col_reg;
    logic [7:0]  o_count_reg;
    logic [31:0] o_rgba_reg;
    logic        o_last_reg;
    logic        o_done_reg;
    logic [15:0] o_width_reg;
    logic [15:0] o_height_reg;

    logic [4:0]  hdr_idx;
    logic [1:0]  err_code;
    logic [2:0]  need;
    logic        pix_complete;
    logic [31:0] rgba;
    logic [16:0] room;
    logic        count_fits;
    logic [7:0]  seg;
    logic [16:0] col_sum;
    logic        wrap;
    logic        seg_done;
    logic        load;

    assign hdr_idx = start_of_file ? HB_ID_LEN : hdr_cnt_reg;

    always_comb
    begin
        priority if ((type_reg != TYPE_RAW) && (type_reg != TYPE_RLE))
            err_code = STAT_BAD_TYPE;
        else if ((map_reg != 8'd0) || ((bpp_reg != BPP_24) && (bpp_reg != BPP_32)))
            err_code = STAT_BAD_FORMAT;
        else if (width_reg < MIN_WIDTH)
            err_code = STAT_NARROW;
        else
            err_code = STAT_SEG;
    end

    assign need         = (bpp_reg == BPP_32) ? 3'd4 : 3'd3;
    assign pix_complete = (({1'b0, bip_reg}) + 3'd1) >= need;
    assign rgba         = (bpp_reg == BPP_32) ? color_reg : {ALPHA_OPAQUE, color_reg[23:0]};

    // One segment of the pending span, cut at the end of the current row.
    assign room       = {1'b0, width_reg} - {1'b0, col_reg};
    assign count_fits = {9'd0, count_reg} <= room;
    assign seg        = count_fits ? count_reg : room[7:0];
    assign col_sum    = {1'b0, col_reg} + {9'd0, seg};
    assign wrap       = col_sum >= {1'b0, width_reg};
    assign seg_done   = wrap && (row_reg == 16'd0);

    assign sts.hdr_last     = (hdr_idx == HB_LAST);
    assign sts.err_code     = err_code;
    assign sts.id_nonzero   = (id_skip_reg != 8'd0);
    assign sts.skip_last    = (id_skip_reg == 8'd1);
    assign sts.height_zero  = (height_reg == 16'd0);
    assign sts.is_rle       = (type_reg == TYPE_RLE);
    assign sts.pix_complete = pix_complete;
    assign sts.pkt_empty    = (pkt_left_reg == 8'd0);
    assign sts.slot_free    = !out_valid_reg || !out_stall;
    assign sts.emit_last    = count_fits || seg_done;
    assign sts.seg_done     = seg_done;

    assign load = cmd.emit_seg || cmd.emit_err;

    always_comb
    begin
        hdr_cnt_next  = hdr_cnt_reg;
        id_skip_next  = id_skip_reg;
        type_next     = type_reg;
        map_next      = map_reg;
        bpp_next      = bpp_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        pkt_left_next = pkt_left_reg;
        pkt_run_next  = pkt_run_reg;
        bip_next      = bip_reg;
        color_next    = color_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        count_next    = count_reg;

        if (cmd.hdr_byte)
        begin
            hdr_cnt_next = (hdr_idx == HB_LAST) ? 5'd0 : hdr_idx + 5'd1;
            unique case (hdr_idx)
                HB_ID_LEN:    id_skip_next = data_byte;
                HB_MAP_TYPE:  map_next = data_byte;
                HB_IMG_TYPE:  type_next = data_byte;
                HB_WIDTH_LO:  width_next = {width_reg[15:8], data_byte};
                HB_WIDTH_HI:  width_next = {data_byte, width_reg[7:0]};
                HB_HEIGHT_LO: height_next = {height_reg[15:8], data_byte};
                HB_HEIGHT_HI: height_next = {data_byte, height_reg[7:0]};
                HB_BPP:       bpp_next = data_byte;
                default:      bpp_next = bpp_reg;
            endcase
        end

        if (cmd.skip_byte)
        begin
            id_skip_next = id_skip_reg - 8'd1;
        end

        // Entering pixel data; rows fill from the bottom of the buffer.
        if (cmd.enter_data)
        begin
            pkt_left_next = 8'd0;
            pkt_run_next  = 1'b0;
            bip_next      = 2'd0;
            color_next    = 32'd0;
            col_next      = 16'd0;
            if (height_reg != 16'd0)
                row_next = height_reg - 16'd1;
        end

        if (cmd.pkt_hdr)
        begin
            pkt_left_next = {1'b0, data_byte[6:0]} + 8'd1;
            pkt_run_next  = data_byte[7];
            bip_next      = 2'd0;
        end

        if (cmd.pix_byte)
        begin
            bip_next = pix_complete ? 2'd0 : bip_reg + 2'd1;
            unique case (bip_reg)
                2'd0: color_next = {24'd0, data_byte};
                2'd1: color_next = {color_reg[31:16], data_byte, color_reg[7:0]};
                2'd2: color_next = {color_reg[31:24], data_byte, color_reg[15:0]};
                2'd3: color_next = {data_byte, color_reg[23:0]};
                default: color_next = color_reg;
            endcase
        end

        if (cmd.start_span)
        begin
            if (type_reg == TYPE_RLE)
            begin
                if (pkt_run_reg)
                begin
                    count_next    = pkt_left_reg;
                    pkt_left_next = 8'd0;
                end
                else
                begin
                    count_next = 8'd1;
                    if (pkt_left_reg != 8'd0)
                        pkt_left_next = pkt_left_reg - 8'd1;
                end
            end
            else
            begin
                count_next = 8'd1;
            end
        end

        if (cmd.emit_seg)
        begin
            count_next = count_reg - seg;
            if (wrap)
            begin
                col_next = 16'd0;
                if (row_reg != 16'd0)
                    row_next = row_reg - 16'd1;
            end
            else
            begin
                col_next = col_sum[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg  <= 5'd0;
            id_skip_reg  <= 8'd0;
            type_reg     <= 8'd0;
            map_reg      <= 8'd0;
            bpp_reg      <= 8'd0;
            width_reg    <= 16'd0;
            height_reg   <= 16'd0;
            pkt_left_reg <= 8'd0;
            pkt_run_reg  <= 1'b0;
            bip_reg      <= 2'd0;
            color_reg    <= 32'd0;
            row_reg      <= 16'd0;
            col_reg      <= 16'd0;
            count_reg    <= 8'd0;
        end
        else
        begin
            hdr_cnt_reg  <= hdr_cnt_next;
            id_skip_reg  <= id_skip_next;
            type_reg     <= type_next;
            map_reg      <= map_next;
            bpp_reg      <= bpp_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            pkt_left_reg <= pkt_left_next;
            pkt_run_reg  <= pkt_run_next;
            bip_reg      <= bip_next;
            color_reg    <= color_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            count_reg    <= count_next;
        end
    end

    // Output word register.
    always_comb
    begin
        priority if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            o_width_reg  <= width_reg;
            o_height_reg <= height_reg;
            if (cmd.emit_seg)
            begin
                o_status_reg <= STAT_SEG;
                o_row_reg    <= row_reg;
                o_col_reg    <= col_reg;
                o_count_reg  <= seg;
                o_rgba_reg   <= rgba;
                o_last_reg   <= count_fits || seg_done;
                o_done_reg   <= seg_done;
            end
            else
            begin
                o_status_reg <= err_code;
                o_row_reg    <= 16'd0;
                o_col_reg    <= 16'd0;
                o_count_reg  <= 8'd0;
                o_rgba_reg   <= 32'd0;
                o_last_reg   <= 1'b1;
                o_done_reg   <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = o_status_reg;
    assign dest_row     = o_row_reg;
    assign start_column = o_col_reg;
    assign pixel_count  = o_count_reg;
    assign red          = o_rgba_reg[23:16];
    assign green        = o_rgba_reg[15:8];
    assign blue         = o_rgba_reg[7:0];
    assign alpha        = o_rgba_reg[31:24];
    assign last_of_run  = o_last_reg;
    assign image_done   = o_done_reg;
    assign image_width  = o_width_reg;
    assign image_height = o_height_reg;

endmodule

>>> rtl/tga_rle_image_decoder.sv
// Top level of the TGA run-length image decoder.
//
// The input channel carries one word per file byte (data_byte) plus
// start_of_file, which marks header byte 0 of a new file and restarts parsing.
// A word moves when in_valid is high and in_stall is low. The output channel
// carries one pixel segment or one error report per word, under out_valid and
// out_stall with the same rule; a stalled output word holds steady.
// Header, image ID and packet header bytes are taken one per cycle and give no
// output. The byte that completes a pixel is taken, then the input stalls
// while the segments of that pixel are produced, one per cycle while the output
// is not stalled, each limited to the rest of the current row. After the
// completing byte is taken, the first segment is loaded into the output
// register once the output slot is free. A header error is reported the same
// way, and the decoder then ignores bytes until the next start_of_file.
// While the receiver stalls, the output word waits in its register and the
// next segment waits until it is taken; input bytes that give no output are
// still accepted meanwhile. Reset (rst_n low, asynchronous) empties the output
// register and returns the parser to header byte 0.
module tga_rle_image_decoder
    import tga_rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] dest_row,
    output logic [15:0] start_column,
    output logic [7:0]  pixel_count,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic        last_of_run,
    output logic        image_done,
    output logic [15:0] image_width,
    output logic [15:0] image_height
);

`include "tga_rle_image_decoder_assert.svh"

    tga_cmd_t cmd;
    tga_sts_t sts;

    // The controller sequences the parse phases and segment emission.
    tga_rle_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .start_of_file (start_of_file),
        .in_stall      (in_stall),
        .sts           (sts),
        .cmd           (cmd)
    );

    // The datapath holds the header fields, pixel assembly, row and column
    // position, and the output word register.
    tga_rle_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .cmd           (cmd),
        .sts           (sts),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .dest_row      (dest_row),
        .start_column  (start_column),
        .pixel_count   (pixel_count),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .last_of_run   (last_of_run),
        .image_done    (image_done),
        .image_width   (image_width),
        .image_height  (image_height)
    );

    // An error report carries no pixels and ends its byte's results.
    `TGA_RLE_ASSERT_IMPLY(a_err_word, out_valid && (status != STAT_SEG), (pixel_count == 8'd0) && last_of_run, "error word malformed")

    // A segment never runs past the end of its row.
    `TGA_RLE_ASSERT_IMPLY(a_seg_in_row, out_valid && (status == STAT_SEG), (pixel_count != 8'd0) && (({1'b0, start_column} + {9'd0, pixel_count}) <= {1'b0, image_width}), "segment crosses row end")

    // While more segments of a pixel are pending, the input stays stalled.
    `TGA_RLE_ASSERT_IMPLY(a_stall_mid_span, out_valid && !last_of_run, in_stall, "input taken during span")

    // A stalled output word stays in place unchanged.
    `TGA_RLE_ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, out_valid && $stable(start_column) && $stable(pixel_count), "stalled word changed")

endmodule

>>> tb/tb_tga_rle_image_decoder.sv
// Self-checking testbench for the TGA run-length image decoder, with its own decoder model.
`timescale 1ns / 1ps

module tb_tga_rle_image_decoder
    import tga_rle_pkg::*;
();

    // Watchdog limit, counted in cycles in which no word moves on either side.
    localparam int STALL_LIMIT = 4000;
    // Length of the long receiver hold-off used to back the decoder up.
    localparam int HOLD_CYCLES = 300;
    // Total input words for the run; random files top up after the directed tests.
    localparam int ITEM_TARGET = 340;
    localparam int MAX_SEGS = 33;
    localparam int MAX_REPORTS = 20;
    localparam logic [7:0] RUN_FLAG = 8'h80;
    localparam logic [7:0] BPP_16 = 8'd16;

    // Parse phases of the decoder model.
    typedef enum logic [2:0] {
        P_HEADER,
        P_SKIP,
        P_PKTHDR,
        P_PIXEL,
        P_DONE,
        P_ERROR
    } phase_t;

    // Receiver stall patterns.
    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    // One output word: a pixel segment or an error report.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] row;
        logic [15:0] col;
        logic [7:0]  npix;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
        logic        done;
        logic [15:0] width;
        logic [15:0] height;
    } seg_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        start_of_file;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [15:0] dest_row;
    logic [15:0] start_column;
    logic [7:0]  pixel_count;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last_of_run;
    logic        image_done;
    logic [15:0] image_width;
    logic [15:0] image_height;

    tga_rle_image_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .start_of_file(start_of_file),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .dest_row     (dest_row),
        .start_column (start_column),
        .pixel_count  (pixel_count),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .last_of_run  (last_of_run),
        .image_done   (image_done),
        .image_width  (image_width),
        .image_height (image_height)
    );

    // Segments and error reports still owed by the decoder, oldest first.
    seg_word_t seg_expect_q[$];

    // Decoder model state.
    phase_t      dec_phase;
    logic [4:0]  hdr_idx;
    logic [7:0]  id_remaining;
    logic [7:0]  img_type;
    logic [7:0]  cmap_type;
    logic [7:0]  pix_bits;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [7:0]  pkt_remaining;
    logic        pkt_repeat;
    logic [1:0]  pix_idx;
    logic [31:0] pix_bgra;
    logic [15:0] cur_row;
    logic [15:0] cur_col;

    // Run statistics and error count.
    int err_count;
    int words_sent;
    int junk_words;
    int results_checked;
    int files_sent;
    int error_reports;
    int max_segs_seen;

    // Sender pacing and receiver hold-off control.
    bit pace_on;
    int burst_left;
    bit hold_req;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder model. It follows the byte stream word by word and queues
    // every segment and error report that the accepted word causes.
    // ------------------------------------------------------------------

    task automatic model_reset();
        dec_phase = P_HEADER;
        hdr_idx = '0;
        id_remaining = '0;
        img_type = '0;
        cmap_type = '0;
        pix_bits = '0;
        img_w = '0;
        img_h = '0;
        pkt_remaining = '0;
        pkt_repeat = 1'b0;
        pix_idx = '0;
        pix_bgra = '0;
        cur_row = '0;
        cur_col = '0;
    endtask

    task automatic expect_error(input logic [1:0] code);
        seg_word_t w;
        w = '0;
        w.status = code;
        w.last = 1'b1;
        w.width = img_w;
        w.height = img_h;
        seg_expect_q.push_back(w);
        dec_phase = P_ERROR;
        error_reports++;
    endtask

    // The header is complete: set up the pixel area, starting at the bottom row.
    task automatic start_pixel_data();
        dec_phase = (img_type == TYPE_RLE) ? P_PKTHDR : P_PIXEL;
        pkt_remaining = '0;
        pkt_repeat = 1'b0;
        pix_idx = '0;
        pix_bgra = '0;
        cur_col = '0;
        if (img_h == 16'd0)
            dec_phase = P_DONE;
        else
            cur_row = img_h - 16'd1;
    endtask

    // Queue `count` pixels of the held color, cut into one segment per row.
    task automatic expect_span(input int unsigned count);
        int unsigned room;
        int unsigned seg_len;
        int          nseg;
        seg_word_t   w;
        logic [31:0] bgra;
        nseg = 0;
        bgra = pix_bgra;
        if (pix_bits != BPP_32)
            bgra[31:24] = ALPHA_OPAQUE;
        while (count > 0 && dec_phase != P_DONE && nseg < MAX_SEGS)
        begin
            room = 32'(img_w) - 32'(cur_col);
            seg_len = (count < room) ? count : room;
            w = '0;
            w.status = STAT_SEG;
            w.row = cur_row;
            w.col = cur_col;
            w.npix = seg_len[7:0];
            w.red = bgra[23:16];
            w.green = bgra[15:8];
            w.blue = bgra[7:0];
            w.alpha = bgra[31:24];
            w.width = img_w;
            w.height = img_h;
            cur_col = cur_col + seg_len[15:0];
            count = count - seg_len;
            if (cur_col >= img_w)
            begin
                cur_col = '0;
                if (cur_row == 16'd0)
                begin
                    w.done = 1'b1;
                    dec_phase = P_DONE;
                end
                else
                    cur_row = cur_row - 16'd1;
            end
            seg_expect_q.push_back(w);
            nseg++;
        end
        if (nseg > 0)
        begin
            w = seg_expect_q.pop_back();
            w.last = 1'b1;
            seg_expect_q.push_back(w);
        end
        if (nseg > max_segs_seen)
            max_segs_seen = nseg;
    endtask

    task automatic predict_decode(input logic [7:0] b, input logic sof);
        logic [2:0] need;
        if (sof)
        begin
            dec_phase = P_HEADER;
            hdr_idx = '0;
        end
        case (dec_phase)
            P_HEADER:
            begin
                case (hdr_idx)
                    HB_ID_LEN:    id_remaining = b;
                    HB_MAP_TYPE:  cmap_type = b;
                    HB_IMG_TYPE:  img_type = b;
                    HB_WIDTH_LO:  img_w[7:0] = b;
                    HB_WIDTH_HI:  img_w[15:8] = b;
                    HB_HEIGHT_LO: img_h[7:0] = b;
                    HB_HEIGHT_HI: img_h[15:8] = b;
                    HB_BPP:       pix_bits = b;
                    default: ;
                endcase
                if (hdr_idx < HB_LAST)
                    hdr_idx = hdr_idx + 5'd1;
                else
                begin
                    // Checks run in a fixed order; the first failing one is reported.
                    hdr_idx = '0;
                    if (img_type != TYPE_RAW && img_type != TYPE_RLE)
                        expect_error(STAT_BAD_TYPE);
                    else if (cmap_type != 8'd0 || (pix_bits != BPP_24 && pix_bits != BPP_32))
                        expect_error(STAT_BAD_FORMAT);
                    else if (img_w < MIN_WIDTH)
                        expect_error(STAT_NARROW);
                    else if (id_remaining != 8'd0)
                        dec_phase = P_SKIP;
                    else
                        start_pixel_data();
                end
            end
            P_SKIP:
            begin
                id_remaining = id_remaining - 8'd1;
                if (id_remaining == 8'd0)
                    start_pixel_data();
            end
            P_PKTHDR:
            begin
                pkt_remaining = {1'b0, b[6:0]} + 8'd1;
                pkt_repeat = b[7];
                pix_idx = '0;
                dec_phase = P_PIXEL;
            end
            P_PIXEL:
            begin
                need = (pix_bits == BPP_32) ? 3'd4 : 3'd3;
                if (pix_idx == 2'd0)
                    pix_bgra = '0;
                pix_bgra = pix_bgra | (32'(b) << (8 * pix_idx));
                if ({1'b0, pix_idx} + 3'd1 < need)
                    pix_idx = pix_idx + 2'd1;
                else
                begin
                    pix_idx = '0;
                    if (img_type != TYPE_RLE)
                        expect_span(1);
                    else
                    begin
                        if (pkt_repeat)
                        begin
                            expect_span(32'(pkt_remaining));
                            pkt_remaining = '0;
                        end
                        else
                        begin
                            expect_span(1);
                            if (pkt_remaining > 8'd0)
                                pkt_remaining = pkt_remaining - 8'd1;
                        end
                        if (dec_phase != P_DONE && pkt_remaining == 8'd0)
                            dec_phase = P_PKTHDR;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side. Words change at the falling edge. The sender works in
    // bursts of random length and leaves random gaps between them; a gap
    // of zero gives stretches with no idling at all.
    // ------------------------------------------------------------------

    task automatic send_word(input logic [7:0] b, input logic sof);
        int gap;
        @(negedge clk);
        if (pace_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
        end
        in_valid <= 1'b1;
        data_byte <= b;
        start_of_file <= sof;
        // The word moves at the first rising edge with in_stall low.
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        words_sent++;
        predict_decode(b, sof);
    endtask

    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Bytes that the decoder ignores: after an error, after the image, or header padding.
    task automatic send_junk(input int n);
        repeat (n)
            send_word(rand_byte(), 1'b0);
        junk_words += n;
    endtask

    task automatic send_header(input logic [7:0] id_len, input logic [7:0] map,
                               input logic [7:0] typ, input logic [15:0] w,
                               input logic [15:0] h, input logic [7:0] bpp,
                               input logic sof);
        logic [7:0] b;
        logic [4:0] idx;
        for (int i = 0; i <= HB_LAST; i++)
        begin
            idx = i[4:0];
            b = rand_byte();
            case (idx)
                HB_ID_LEN:    b = id_len;
                HB_MAP_TYPE:  b = map;
                HB_IMG_TYPE:  b = typ;
                HB_WIDTH_LO:  b = w[7:0];
                HB_WIDTH_HI:  b = w[15:8];
                HB_HEIGHT_LO: b = h[7:0];
                HB_HEIGHT_HI: b = h[15:8];
                HB_BPP:       b = bpp;
                default: ;
            endcase
            send_word(b, (i == 0) ? sof : 1'b0);
        end
        files_sent++;
    endtask

    // Pixel bytes go out in file order: blue, green, red, then alpha for 32 bits.
    task automatic send_pixel_value(input logic [7:0] bpp, input logic [31:0] bgra);
        send_word(bgra[7:0], 1'b0);
        send_word(bgra[15:8], 1'b0);
        send_word(bgra[23:16], 1'b0);
        if (bpp == BPP_32)
            send_word(bgra[31:24], 1'b0);
    endtask

    task automatic send_pixel(input logic [7:0] bpp);
        send_pixel_value(bpp, {rand_byte(), rand_byte(), rand_byte(), rand_byte()});
    endtask

    task automatic send_packet(input bit run, input int n);
        logic [7:0] hdr;
        hdr = 8'(n - 1);
        hdr[7] = run;
        send_word(hdr, 1'b0);
    endtask

    // Run-length pixel data for `total` pixels. Now and then a packet runs past
    // the end of the image, which the decoder must cut off.
    task automatic send_rle_body(input int total, input logic [7:0] bpp, input bit raw_ok);
        int left;
        int n;
        bit run;
        left = total;
        while (left > 0)
        begin
            run = !raw_ok || ($urandom_range(0, 9) < 6);
            if (run)
                n = $urandom_range(1, (left < 128) ? left : 128);
            else
                n = $urandom_range(1, (left < 4) ? left : 4);
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(1, run ? 128 : 6);
            send_packet(run, n);
            if (run)
                send_pixel(bpp);
            else
                repeat (n) send_pixel(bpp);
            left -= n;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side. The receiver stalls on its own pattern, changing mode
    // after each random window, and holds off for a long stretch on request.
    // ------------------------------------------------------------------

    initial
    begin
        int window;
        rx_mode_t mode;
        out_stall = 1'b0;
        window = 0;
        mode = RX_FREE;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (window == 0)
                begin
                    window = $urandom_range(8, 64);
                    mode = rx_mode_t'($urandom_range(0, 3));
                end
                window--;
                case (mode)
                    RX_FREE:     out_stall <= 1'b0;
                    RX_LIGHT:    out_stall <= ($urandom_range(0, 4) == 0);
                    RX_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
                    default:     out_stall <= (window % 3 == 0);
                endcase
            end
        end
    end

    // Every word taken from the output is compared with the oldest expectation.
    always @(posedge clk)
    begin
        seg_word_t got;
        seg_word_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = {status, dest_row, start_column, pixel_count, red, green, blue, alpha,
                   last_of_run, image_done, image_width, image_height};
            if (seg_expect_q.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected output word st=%0d row=%0d col=%0d n=%0d",
                             $time, got.status, got.row, got.col, got.npix);
            end
            else
            begin
                want = seg_expect_q.pop_front();
                results_checked++;
                if (got !== want)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch expected st=%0d row=%0d col=%0d n=%0d",
                                 $time, want.status, want.row, want.col, want.npix);
                        $display("    rgba=%02h%02h%02h%02h last=%0b done=%0b w=%0d h=%0d",
                                 want.red, want.green, want.blue, want.alpha,
                                 want.last, want.done, want.width, want.height);
                        $display("  actual st=%0d row=%0d col=%0d n=%0d",
                                 got.status, got.row, got.col, got.npix);
                        $display("    rgba=%02h%02h%02h%02h last=%0b done=%0b w=%0d h=%0d",
                                 got.red, got.green, got.blue, got.alpha,
                                 got.last, got.done, got.width, got.height);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        int quiet;
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles, %0d results still owed",
                     $time, quiet, seg_expect_q.size());
            $display("tb_tga_rle_image_decoder: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // The first file after reset comes without a start marker and must still
    // parse; the bytes after its last pixel are ignored.
    task automatic test_no_marker_after_reset();
        send_header(8'd0, 8'd0, TYPE_RLE, 16'd4, 16'd2, BPP_24, 1'b0);
        send_packet(1'b1, 128);
        send_pixel_value(BPP_24, 32'h00FF_FFFF);
        send_junk(3);
    endtask

    // A run of 128 that starts mid-row on the narrowest width gives the most
    // segments from one word, and the image ends with a second run.
    task automatic test_long_run_narrow();
        send_header(8'd0, 8'd0, TYPE_RLE, MIN_WIDTH, 16'd40, BPP_32, 1'b1);
        send_packet(1'b0, 2);
        send_pixel_value(BPP_32, 32'h0000_0000);
        send_pixel_value(BPP_32, 32'hFFFF_FFFF);
        send_packet(1'b1, 128);
        send_pixel(BPP_32);
        send_packet(1'b1, 30);
        send_pixel(BPP_32);
        send_junk(2);
    endtask

    // Uncompressed image with an image ID field to skip.
    task automatic test_raw_with_id();
        send_header(8'd3, 8'd0, TYPE_RAW, 16'd4, 16'd2, BPP_24, 1'b1);
        send_junk(3);
        repeat (8) send_pixel(BPP_24);
        send_junk(3);
    endtask

    // Each header check, plus a header that fails two checks at once.
    task automatic test_header_errors();
        send_header(8'd5, 8'd0, 8'd3, 16'd8, 16'd2, BPP_24, 1'b1);
        send_junk(2);
        send_header(8'd0, 8'hFF, 8'h00, 16'd8, 16'd2, BPP_16, 1'b1);
        send_junk(1);
        send_header(8'd0, 8'd1, TYPE_RLE, 16'd8, 16'd2, BPP_24, 1'b1);
        send_junk(2);
        send_header(8'd0, 8'd0, TYPE_RAW, 16'd8, 16'd2, BPP_16, 1'b1);
        send_header(8'd0, 8'd0, TYPE_RLE, 16'd3, 16'd2, BPP_32, 1'b1);
        send_junk(2);
    endtask

    // Images with no rows give no result at all.
    task automatic test_zero_height();
        send_header(8'd0, 8'd0, TYPE_RLE, 16'hFFFF, 16'd0, BPP_32, 1'b1);
        send_word(RUN_FLAG, 1'b0);
        send_junk(4);
    endtask

    // A start marker in mid-pixel and one in mid-header both restart the parse.
    task automatic test_restart_mid_file();
        send_header(8'd1, 8'd0, TYPE_RLE, 16'hFFFF, 16'hFFFF, BPP_32, 1'b1);
        send_junk(1);
        send_packet(1'b1, 128);
        send_pixel(BPP_32);
        send_packet(1'b0, 3);
        send_pixel(BPP_32);
        send_word(rand_byte(), 1'b0);
        send_word(rand_byte(), 1'b0);
        for (int i = 0; i < 9; i++)
            send_word(rand_byte(), i == 0);
        send_header(8'd0, 8'd0, TYPE_RAW, 16'd4, 16'd1, BPP_24, 1'b1);
        send_pixel_value(BPP_24, 32'h0000_0000);
        send_pixel_value(BPP_24, 32'h00FF_FFFF);
        send_pixel(BPP_24);
        send_pixel(BPP_24);
    endtask

    // The receiver holds off for a long stretch while the sender keeps going,
    // so the decoder fills up and has to stall its input.
    task automatic test_backpressure_fill();
        pace_on = 1'b0;
        hold_req = 1'b1;
        send_header(8'd0, 8'd0, TYPE_RLE, MIN_WIDTH, 16'd64, BPP_24, 1'b1);
        repeat (4)
        begin
            send_packet(1'b1, 64);
            send_pixel(BPP_24);
        end
        pace_on = 1'b1;
    endtask

    // One random file: mostly well-formed images with random content, some
    // cut short, some with broken headers, and some plain noise.
    task automatic send_random_file();
        int kind;
        int total;
        int w;
        int h;
        int id_len;
        bit wide;
        logic [7:0] typ;
        logic [7:0] bpp;
        logic [7:0] bad;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            wide = ($urandom_range(0, 9) == 0);
            typ = (wide || $urandom_range(0, 3) != 0) ? TYPE_RLE : TYPE_RAW;
            bpp = $urandom_range(0, 1) ? BPP_32 : BPP_24;
            id_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            if (wide)
            begin
                w = $urandom_range(4, 300);
                h = 1;
            end
            else
            begin
                w = $urandom_range(4, 9);
                h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
            end
            send_header(8'(id_len), 8'd0, typ, 16'(w), 16'(h), bpp, 1'b1);
            repeat (id_len) send_word(rand_byte(), 1'b0);
            total = w * h;
            if (total == 0)
                send_junk($urandom_range(1, 4));
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    total = $urandom_range(0, total - 1);
                if (typ == TYPE_RLE)
                    send_rle_body(total, bpp, !wide);
                else
                    repeat (total) send_pixel(bpp);
                // A cut-short image may also stop inside a pixel or packet.
                if (total < w * h && $urandom_range(0, 1) == 1)
                    repeat ($urandom_range(1, 2)) send_word(rand_byte(), 1'b0);
                else
                    send_junk($urandom_range(0, 3));
            end
        end
        else if (kind < 85)
        begin
            typ = TYPE_RLE;
            bpp = BPP_24;
            w = $urandom_range(4, 8);
            bad = 8'd0;
            case ($urandom_range(0, 3))
                0:
                    do
                        typ = 8'($urandom_range(0, 255));
                    while (typ == TYPE_RAW || typ == TYPE_RLE);
                1: bad = 8'($urandom_range(1, 255));
                2:
                    do
                        bpp = 8'($urandom_range(0, 255));
                    while (bpp == BPP_24 || bpp == BPP_32);
                default: w = $urandom_range(0, 3);
            endcase
            send_header(8'($urandom_range(0, 3)), bad, typ, 16'(w),
                        16'($urandom_range(0, 3)), bpp, 1'b1);
            send_junk($urandom_range(0, 2));
        end
        else
        begin
            for (int i = 0; i < 18; i++)
                send_word(rand_byte(), i == 0);
            files_sent++;
            send_junk($urandom_range(0, 3));
        end
    endtask

    task automatic test_random_files();
        do
            send_random_file();
        while (words_sent < ITEM_TARGET);
    endtask

    // Wait until every owed result has arrived, then keep watching in case
    // the decoder emits something extra.
    task automatic finish_run();
        @(negedge clk);
        in_valid <= 1'b0;
        while (seg_expect_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Covered %0d files and %0d input words (%0d ignored); %0d result words checked.",
                 files_sent, words_sent, junk_words, results_checked);
        $display("Error reports: %0d; most segments from one word: %0d.",
                 error_reports, max_segs_seen);
        if (err_count == 0)
            $display("tb_tga_rle_image_decoder: done, clean");
        else
            $display("tb_tga_rle_image_decoder: done, errors");
        $finish;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'd0;
        start_of_file = 1'b0;
        hold_req = 1'b0;
        pace_on = 1'b1;
        burst_left = 0;
        err_count = 0;
        words_sent = 0;
        junk_words = 0;
        results_checked = 0;
        files_sent = 0;
        error_reports = 0;
        max_segs_seen = 0;
        model_reset();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_no_marker_after_reset();
        test_long_run_narrow();
        test_raw_with_id();
        test_header_errors();
        test_zero_height();
        test_restart_mid_file();
        test_backpressure_fill();
        test_random_files();
        finish_run();
    end

endmodule
